>>> src/unsigned_divide_with_fault_top_assert.svh
// Assertion macros for the unsigned divider.
`ifndef UNSIGNED_DIVIDE_WITH_FAULT_TOP_ASSERT_SVH
`define UNSIGNED_DIVIDE_WITH_FAULT_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define UDF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("udf assertion failed");
// Check that a condition never holds outside reset.
`define UDF_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("udf forbidden condition seen");
`else
`define UDF_ASSERT(lbl, clk, rst_n, prop)
`define UDF_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

>>> src/udf_pkg.sv
`default_nettype none
package udf_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned NumCells = WordW;

  // Operand size codes carried with each request.
  localparam logic [1:0] CMD_SIZE8  = 2'd0;
  localparam logic [1:0] CMD_SIZE16 = 2'd1;
  localparam logic [1:0] CMD_SIZE32 = 2'd2;

  typedef enum logic [1:0] {
    FAULT_NONE = 2'd0,
    FAULT_ZERO = 2'd1,
    FAULT_OVFL = 2'd2
  } fault_e;

  // Data handed from one divider cell to the next.
  typedef struct packed {
    logic [1:0]       cmd;
    fault_e           fault;
    logic [WordW-1:0] rem;
    logic [WordW-1:0] low;
    logic [WordW-1:0] quo;
    logic [WordW-1:0] div;
  } stage_t;

  typedef struct packed {
    logic [WordW-1:0] quotient;
    logic [WordW-1:0] remainder;
    fault_e           fault;
  } result_t;

endpackage
`default_nettype wire

>>> src/udf_cell.sv
`default_nettype none
module udf_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic [4:0]          idx_i,
  input  wire logic                valid_i,
  input  wire udf_pkg::stage_t     stage_i,
  output logic                     valid_o,
  output udf_pkg::stage_t          stage_o
);
  import udf_pkg::*;

  logic             active;
  logic [WordW:0]   shifted;
  logic [WordW:0]   diff;
  stage_t           stage_d;
  stage_t           stage_q;
  logic             valid_q;

  // Enable only the last n cells for an n-bit divide.
  always_comb begin
    case (stage_i.cmd)
      CMD_SIZE8:  active = (idx_i[4:3] == 2'b11);
      CMD_SIZE16: active = idx_i[4];
      default:    active = 1'b1;
    endcase
  end

  // One restoring step: shift in the next dividend bit, trial subtract.
  always_comb begin
    shifted = {stage_i.rem, stage_i.low[WordW-1]};
    diff    = shifted - {1'b0, stage_i.div};
    stage_d = stage_i;
    if (active) begin
      stage_d.low = {stage_i.low[WordW-2:0], 1'b0};
      if (!diff[WordW]) begin
        stage_d.rem = diff[WordW-1:0];
        stage_d.quo = {stage_i.quo[WordW-2:0], 1'b1};
      end else begin
        stage_d.rem = shifted[WordW-1:0];
        stage_d.quo = {stage_i.quo[WordW-2:0], 1'b0};
      end
    end
  end

  // Advance the request one cell when the chain moves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule
`default_nettype wire

>>> src/udf_out.sv
`default_nettype none
module udf_out (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire udf_pkg::stage_t   stage_i,
  output logic                   en_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output udf_pkg::result_t       result_o,
  output logic                   skid_valid_o
);
  import udf_pkg::*;

  result_t res_d;
  result_t out_q;
  result_t skid_q;
  logic    out_valid_q;
  logic    skid_valid_q;
  logic    load;
  logic    take;

  // Zero both results on a fault.
  always_comb begin
    res_d.fault = stage_i.fault;
    if (stage_i.fault == FAULT_NONE) begin
      res_d.quotient  = stage_i.quo;
      res_d.remainder = stage_i.rem;
    end else begin
      res_d.quotient  = '0;
      res_d.remainder = '0;
    end
  end

  assign en_o = !skid_valid_q;
  assign load = valid_i && en_o;
  assign take = out_ready_i || !out_valid_q;

  // Hold a finished request in the skid stage while the receiver stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (take) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= load;
      end
    end else if (load) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (load) begin
        out_q <= res_d;
      end
    end else if (load) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign result_o     = out_q;
  assign skid_valid_o = skid_valid_q;

endmodule
`default_nettype wire

>>> src/unsigned_divide_with_fault_top.sv
// Unsigned divider with fault report, three operand sizes.
// Input channel: in_valid_i / in_ready_o with cmd_i (0 = 8, 1 = 16, 2 = 32
// bits, 3 acts as 32), dividend_i (low 2n bits used) and divisor_i (low n
// bits used). Output channel: out_valid_o / out_ready_i with quotient_o,
// remainder_o and fault_o (0 ok, 1 divide by zero, 2 quotient overflow).
// On a fault quotient and remainder are zero.
// Each request passes a decode register, a chain of 32 restoring cells (one
// quotient bit per active cell) and an output register, whatever the operand
// size.
// Throughput is one request per cycle while the chain is not frozen; the cells
// form a pipeline and requests are independent.
// When the receiver stalls, one finished result waits in the output register
// and the next one in a skid register; only once the skid register is full
// does the whole chain freeze and in_ready_o go low. in_ready_o comes from a
// register and does not depend on out_ready_i in the same cycle.
// Reset clears all valid flags; no request is in flight afterwards.
`default_nettype none
module unsigned_divide_with_fault_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [1:0]                cmd_i,
  input  wire logic [63:0]               dividend_i,
  input  wire logic [31:0]               divisor_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [31:0]                    quotient_o,
  output logic [31:0]                    remainder_o,
  output logic [1:0]                     fault_o
);
  import udf_pkg::*;

  stage_t  prep_d;
  stage_t  prep_q;
  logic    prep_valid_q;
  logic    en;
  logic    skid_valid;
  result_t result;
  stage_t  chain   [NumCells+1];
  logic    chain_v [NumCells+1];

  // Split the dividend into high and low halves and mask the divisor per operand size.
  always_comb begin
    prep_d.cmd = cmd_i;
    prep_d.quo = '0;
    case (cmd_i)
      CMD_SIZE8: begin
        prep_d.rem = {24'd0, dividend_i[15:8]};
        prep_d.low = {dividend_i[7:0], 24'd0};
        prep_d.div = {24'd0, divisor_i[7:0]};
      end
      CMD_SIZE16: begin
        prep_d.rem = {16'd0, dividend_i[31:16]};
        prep_d.low = {dividend_i[15:0], 16'd0};
        prep_d.div = {16'd0, divisor_i[15:0]};
      end
      default: begin
        prep_d.rem = dividend_i[63:32];
        prep_d.low = dividend_i[31:0];
        prep_d.div = divisor_i;
      end
    endcase
    // Overflow when the high half is not below the divisor.
    if (prep_d.div == '0) begin
      prep_d.fault = FAULT_ZERO;
    end else if (prep_d.rem >= prep_d.div) begin
      prep_d.fault = FAULT_OVFL;
    end else begin
      prep_d.fault = FAULT_NONE;
    end
  end

  assign in_ready_o = en;

  // Register the decoded request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_valid_q <= 1'b0;
    end else if (en) begin
      prep_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prep_q <= prep_d;
    end
  end

  assign chain[0]   = prep_q;
  assign chain_v[0] = prep_valid_q;

  // Chain of restoring cells, one quotient bit per active cell.
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    udf_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .idx_i   (5'(k)),
      .valid_i (chain_v[k]),
      .stage_i (chain[k]),
      .valid_o (chain_v[k+1]),
      .stage_o (chain[k+1])
    );
  end

  udf_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (chain_v[NumCells]),
    .stage_i      (chain[NumCells]),
    .en_o         (en),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (result),
    .skid_valid_o (skid_valid)
  );

  assign quotient_o  = result.quotient;
  assign remainder_o = result.remainder;
  assign fault_o     = result.fault;

`include "unsigned_divide_with_fault_top_assert.svh"

  `UDF_ASSERT(a_fault_zeroes, clk_i, rst_ni, (out_valid_o && (fault_o != FAULT_NONE)) |-> ((quotient_o == '0) && (remainder_o == '0)))
  `UDF_ASSERT_NEVER(a_skid_without_out, clk_i, rst_ni, skid_valid && !out_valid_o)
  `UDF_ASSERT(a_stall_fills_skid, clk_i, rst_ni, (chain_v[NumCells] && en && out_valid_o && !out_ready_i) |=> skid_valid)

endmodule
`default_nettype wire

>>> tb/udf_result_checker.sv
`timescale 1ns / 1ps
// Watch both channels of the divider, predict each result from the accepted
// request and compare it with what comes out, oldest first.
module udf_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  cmd_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] quotient_i,
  input  logic [31:0] remainder_i,
  input  logic [1:0]  fault_i,
  output int          err_cnt_o,
  output int          pending_o,
  output int          checked_o,
  output int          zero_cnt_o,
  output int          ovfl_cnt_o
);
  import udf_pkg::*;

  result_t pending_divides[$];
  int      errors  = 0;
  int      checked = 0;
  int      zeros   = 0;
  int      ovfls   = 0;

  initial begin
    err_cnt_o  = 0;
    pending_o  = 0;
    checked_o  = 0;
    zero_cnt_o = 0;
    ovfl_cnt_o = 0;
  end

  // Unsigned divide of the low 2n dividend bits by the low n divisor bits.
  function automatic result_t udiv_result(logic [1:0] size, logic [63:0] num,
                                          logic [31:0] den);
    logic [63:0] nmask;
    logic [63:0] dmask;
    logic [63:0] n;
    logic [63:0] d;
    logic [63:0] q;
    logic [63:0] r;
    result_t     res;
    case (size)
      CMD_SIZE8: begin
        nmask = 64'h0000_0000_0000_FFFF;
        dmask = 64'h0000_0000_0000_00FF;
      end
      CMD_SIZE16: begin
        nmask = 64'h0000_0000_FFFF_FFFF;
        dmask = 64'h0000_0000_0000_FFFF;
      end
      // the unused size code decodes as 32-bit
      default: begin
        nmask = 64'hFFFF_FFFF_FFFF_FFFF;
        dmask = 64'h0000_0000_FFFF_FFFF;
      end
    endcase
    n = num & nmask;
    d = {32'b0, den} & dmask;
    res.quotient  = '0;
    res.remainder = '0;
    res.fault     = FAULT_NONE;
    // zero divisor wins over the overflow test
    if (d == 64'd0) begin
      res.fault = FAULT_ZERO;
    end else begin
      q = n / d;
      r = n % d;
      if (q > dmask) begin
        res.fault = FAULT_OVFL;
      end else begin
        res.quotient  = q[31:0];
        res.remainder = r[31:0];
      end
    end
    return res;
  endfunction

  always @(posedge clk_i) begin : watch
    result_t want;
    if (rst_ni) begin
      // compare a result leaving the block with the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (pending_divides.size() == 0) begin
          errors++;
          $display("%0t: result with nothing outstanding: q=%h r=%h fault=%0d",
                   $time, quotient_i, remainder_i, fault_i);
        end else begin
          want = pending_divides.pop_front();
          checked++;
          if (want.fault == FAULT_ZERO) zeros++;
          if (want.fault == FAULT_OVFL) ovfls++;
          if (quotient_i !== want.quotient) begin
            errors++;
            $display("%0t: quotient mismatch: expected %h, got %h",
                     $time, want.quotient, quotient_i);
          end
          if (remainder_i !== want.remainder) begin
            errors++;
            $display("%0t: remainder mismatch: expected %h, got %h",
                     $time, want.remainder, remainder_i);
          end
          if (fault_i !== want.fault) begin
            errors++;
            $display("%0t: fault mismatch: expected %0d, got %0d",
                     $time, want.fault, fault_i);
          end
        end
      end
      // predict the result of each accepted request
      if (in_valid_i && in_ready_i) begin
        pending_divides.push_back(udiv_result(cmd_i, dividend_i, divisor_i));
      end
    end
    err_cnt_o  <= errors;
    pending_o  <= pending_divides.size();
    checked_o  <= checked;
    zero_cnt_o <= zeros;
    ovfl_cnt_o <= ovfls;
  end

endmodule

>>> tb/tb_unsigned_divide_with_fault_top.sv
`timescale 1ns / 1ps
module tb_unsigned_divide_with_fault_top;
  import udf_pkg::*;

  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int NumRandom  = 530;
  localparam int HoldAt     = 150;
  localparam int HoldLen    = 200;
  localparam int CalmFrom   = 300;
  localparam int CalmTo     = 420;
  localparam int TailCycles = 40;
  localparam int StallLimit = 3000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i       = '0;
  logic [63:0] dividend_i  = '0;
  logic [31:0] divisor_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] quotient_o;
  logic [31:0] remainder_o;
  logic [1:0]  fault_o;

  int   accepted_cnt = 0;
  int   stall_cycles = 0;
  int   hold_left    = 0;
  logic hold_done    = 1'b0;
  int   err_cnt;
  int   pending_cnt;
  int   checked_cnt;
  int   zero_cnt;
  int   ovfl_cnt;
  logic calm;

  // no idling on either side inside this window
  assign calm = (accepted_cnt >= CalmFrom) && (accepted_cnt < CalmTo);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  unsigned_divide_with_fault_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .dividend_i (dividend_i),
    .divisor_i  (divisor_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .quotient_o (quotient_o),
    .remainder_o(remainder_o),
    .fault_o    (fault_o)
  );

  udf_result_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .cmd_i      (cmd_i),
    .dividend_i (dividend_i),
    .divisor_i  (divisor_i),
    .out_valid_i(out_valid_o),
    .out_ready_i(out_ready_i),
    .quotient_i (quotient_o),
    .remainder_i(remainder_o),
    .fault_i    (fault_o),
    .err_cnt_o  (err_cnt),
    .pending_o  (pending_cnt),
    .checked_o  (checked_cnt),
    .zero_cnt_o (zero_cnt),
    .ovfl_cnt_o (ovfl_cnt)
  );

  // Count accepted requests and end the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) accepted_cnt <= accepted_cnt + 1;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= StallLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
        $display("unsigned_divide_with_fault_top verification failed");
        $finish;
      end
    end
  end

  // Receiver: random stalls, one long hold-off to back the pipeline up.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (!hold_done && accepted_cnt >= HoldAt) begin
      hold_done   <= 1'b1;
      hold_left   <= HoldLen - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= 7);
    end
  end

  // Offer one request, idling at random first; return once it is accepted.
  task automatic offer(input logic [1:0] c, input logic [63:0] a,
                       input logic [31:0] b);
    while (!calm && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= c;
    dividend_i <= a;
    divisor_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Build a random divide: mostly in range, plus zero divisors, boundary
  // overflows and raw noise, with junk above the used bits.
  task automatic random_divide(output logic [1:0] c, output logic [63:0] num,
                               output logic [31:0] den);
    logic [63:0] nmask;
    logic [63:0] dmask;
    logic [63:0] d;
    logic [63:0] q;
    int          pick;
    pick = $urandom_range(99);
    c    = 2'($urandom_range(3));
    case (c)
      CMD_SIZE8: begin
        nmask = 64'h0000_0000_0000_FFFF;
        dmask = 64'h0000_0000_0000_00FF;
      end
      CMD_SIZE16: begin
        nmask = 64'h0000_0000_FFFF_FFFF;
        dmask = 64'h0000_0000_0000_FFFF;
      end
      default: begin
        nmask = 64'hFFFF_FFFF_FFFF_FFFF;
        dmask = 64'h0000_0000_FFFF_FFFF;
      end
    endcase
    d = 64'($urandom >> $urandom_range(31)) & dmask;
    if (d == 64'd0) d = 64'd1;
    if (pick < 70) begin
      q   = 64'($urandom >> $urandom_range(31)) & dmask;
      num = q * d + 64'($urandom) % d;
    end else if (pick < 80) begin
      d   = 64'd0;
      num = {$urandom, $urandom};
    end else if (pick < 88) begin
      // quotient just past the operand width
      num = (dmask + 64'd1) * d + 64'($urandom) % d;
    end else begin
      num = {$urandom, $urandom};
      d   = 64'($urandom);
    end
    if ($urandom_range(1) == 1) num = num | ({$urandom, $urandom} & ~nmask);
    den = d[31:0];
    if ($urandom_range(1) == 1) den = den | ($urandom & ~dmask[31:0]);
  endtask

  initial begin : stimulus
    logic [1:0]  c;
    logic [63:0] a;
    logic [31:0] b;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 8-bit: smallest, largest quotient, overflow edges, ignored high bits
    offer(CMD_SIZE8,  64'h0000, 32'h01);
    offer(CMD_SIZE8,  64'hFEFF, 32'hFF);
    offer(CMD_SIZE8,  64'hFF00, 32'hFF);
    offer(CMD_SIZE8,  64'hFFFF, 32'hFF);
    offer(CMD_SIZE8,  64'h1234, 32'hFFFF_FF00);
    offer(CMD_SIZE8,  64'hFFFF_FFFF_FFFF_0064, 32'hFFFF_FF07);
    // 16-bit
    offer(CMD_SIZE16, 64'hFFFE_FFFF, 32'hFFFF);
    offer(CMD_SIZE16, 64'hFFFF_0000, 32'hFFFF);
    offer(CMD_SIZE16, 64'hFFFF_FFFF, 32'h0001);
    offer(CMD_SIZE16, 64'h0000_FFFF, 32'h0001);
    offer(CMD_SIZE16, 64'hABCD_0000_1234_5678, 32'hFFFF_0000);
    offer(CMD_SIZE16, 64'hFFFF_FFFF_0000_0007, 32'hABCD_0003);
    // 32-bit
    offer(CMD_SIZE32, 64'hFFFF_FFFE_FFFF_FFFF, 32'hFFFF_FFFF);
    offer(CMD_SIZE32, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    offer(CMD_SIZE32, 64'hFFFF_FFFF_0000_0000, 32'hFFFF_FFFF);
    offer(CMD_SIZE32, 64'h0, 32'h0);
    offer(CMD_SIZE32, 64'h0000_0000_FFFF_FFFF, 32'h1);
    offer(CMD_SIZE32, 64'h0000_0001_0000_0000, 32'h1);
    offer(CMD_SIZE32, 64'd12345, 32'h10);
    // unused size code acts as 32-bit
    offer(CmdUnused,  64'hFFFF_FFFE_FFFF_FFFF, 32'hFFFF_FFFF);
    offer(CmdUnused,  64'h5, 32'h0);
    offer(CmdUnused,  64'h0000_0001_0000_0000, 32'h2);

    // pause until the directed results are all back
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);

    for (int i = 0; i < NumRandom; i++) begin
      random_divide(c, a, b);
      offer(c, a, b);
    end
    in_valid_i <= 1'b0;

    // drain, then allow for anything still in the pipeline
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Run covered %0d divides at all four size codes, %0d results checked",
             accepted_cnt, checked_cnt);
    $display("  of which %0d divide-by-zero and %0d overflow, with a %0d-cycle backpressure hold",
             zero_cnt, ovfl_cnt, HoldLen);
    if (err_cnt == 0 && pending_cnt == 0) begin
      $display("unsigned_divide_with_fault_top verification clean");
    end else begin
      $display("unsigned_divide_with_fault_top verification failed");
    end
    $finish;
  end

endmodule

>>> unsigned_divide_with_fault_top.f
+incdir+src
src/udf_pkg.sv
src/udf_cell.sv
src/udf_out.sv
src/unsigned_divide_with_fault_top.sv
tb/udf_result_checker.sv
tb/tb_unsigned_divide_with_fault_top.sv
